### rtl/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types and constants for the indexed list store.
// ----------------------------------------------------------------------------
package ils_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = 11;   // width of the count field
    localparam int POS_W    = 12;
    localparam int DATA_W   = 32;
    localparam int STAT_W   = 2;

    typedef enum logic [2:0] {
        CMD_GET      = 3'd0,
        CMD_INS_HEAD = 3'd1,
        CMD_INS_TAIL = 3'd2,
        CMD_INS_AT   = 3'd3,
        CMD_DELETE   = 3'd4
    } ils_cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE  = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } ils_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GET,
        ST_SHIFT
    } ils_state_t;

endpackage

### rtl/ils_ram.sv
// ----------------------------------------------------------------------------
// ils_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ils_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/indexed_list_store_core.sv
// ----------------------------------------------------------------------------
// indexed_list_store_core
// Ordered list of signed 32-bit values held in one RAM; commands get,
// insert (head, tail, before index) and delete, one result per command.
// ----------------------------------------------------------------------------
// Results: rejected or unknown commands strobe done in the cycle after the
//   transfer; a valid get reads the RAM at the transfer and answers from ST_GET.
// Insert/delete: busy holds while the one-entry-per-cycle RAM shift loop
//   moves the entries, and no new command is taken; done strobes as busy
//   drops. The receiver cannot stall.
// Reset (rst_n low, async): count and control clear; RAM keeps its contents.
// ----------------------------------------------------------------------------
module indexed_list_store_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [2:0]                   cmd,
    input  logic signed [ils_pkg::POS_W-1:0]  position,
    input  logic signed [ils_pkg::DATA_W-1:0] item_value,
    output logic                         done,
    output logic signed [ils_pkg::DATA_W-1:0] read_value,
    output logic [ils_pkg::STAT_W-1:0]   status,
    output logic [ils_pkg::CNT_W-1:0]    count
);

    import ils_pkg::*;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    ils_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;      // list length
    logic [ADDR_W-1:0] rd_ptr_reg, rd_ptr_next;    // next RAM read address
    logic [CNT_W-1:0]  left_reg, left_next;        // reads still to issue
    logic              pend_reg, pend_next;        // RAM read data in flight
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic              ins_reg, ins_next;          // 1: insert, 0: delete
    logic [ADDR_W-1:0] at_reg, at_next;            // insert slot
    logic [DATA_W-1:0] val_reg, val_next;          // value to insert

    // result registers
    logic              done_reg, done_next;
    logic [DATA_W-1:0] rv_reg, rv_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [CNT_W-1:0]  cnt_out_reg, cnt_out_next;

    // RAM port
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    logic accept;

    // ------------------------------------------------------------------
    // Command decode (valid only on a transfer)
    // ------------------------------------------------------------------
    logic              pos_neg;     // position below zero
    logic              pos_ge_cnt;  // position at or past the count
    logic              pos_gt_cnt;  // position past the count
    logic              list_full;
    logic              dec_get;     // issue a RAM read for get
    logic              dec_shift;   // start an insert/delete shift
    logic              dec_ins;
    logic [ADDR_W-1:0] dec_at;
    logic [CNT_W-1:0]  dec_left;
    logic [ADDR_W-1:0] dec_rdptr;
    logic [STAT_W-1:0] dec_status;
    logic [DATA_W-1:0] dec_rv;
    logic [CNT_W-1:0]  count_m1;

    assign accept     = start && (state_reg == ST_IDLE);
    assign busy       = (state_reg != ST_IDLE);
    assign pos_neg    = position[POS_W-1];
    assign pos_ge_cnt = position >= $signed({1'b0, count_reg});
    assign pos_gt_cnt = position >  $signed({1'b0, count_reg});
    assign list_full  = (count_reg == CAP_CNT);
    assign count_m1   = count_reg - CNT_W'(1);

    always_comb
    begin
        dec_get    = 1'b0;
        dec_shift  = 1'b0;
        dec_ins    = 1'b1;
        dec_at     = '0;
        dec_status = STAT_DONE;
        dec_rv     = '0;
        unique case (cmd)
            CMD_GET:
            begin
                if (pos_neg || pos_ge_cnt)
                begin
                    dec_status = STAT_RANGE;
                    dec_rv     = '1;    // -1
                end
                else
                begin
                    dec_get = 1'b1;
                end
            end
            CMD_INS_HEAD:
            begin
                if (list_full)
                    dec_status = STAT_FULL;
                else
                    dec_shift = 1'b1;
            end
            CMD_INS_TAIL:
            begin
                dec_at = count_reg[ADDR_W-1:0];
                if (list_full)
                    dec_status = STAT_FULL;
                else
                    dec_shift = 1'b1;
            end
            CMD_INS_AT:
            begin
                // range check ranks ahead of the full check here
                if (!pos_neg && pos_gt_cnt)
                begin
                    dec_status = STAT_RANGE;
                end
                else if (list_full)
                begin
                    dec_status = STAT_FULL;
                end
                else
                begin
                    dec_shift = 1'b1;
                    if (!pos_neg)
                        dec_at = position[ADDR_W-1:0];
                end
            end
            CMD_DELETE:
            begin
                dec_ins = 1'b0;
                dec_at  = position[ADDR_W-1:0];
                if (pos_neg || pos_ge_cnt)
                    dec_status = STAT_RANGE;
                else
                    dec_shift = 1'b1;
            end
            default:
            begin
                // unknown code: no change, status done
            end
        endcase
    end

    // insert moves [at, count-1] up from the top; delete moves
    // [at+1, count-1] down from the bottom
    always_comb
    begin
        if (dec_ins)
        begin
            dec_left  = count_reg - CNT_W'(dec_at);
            dec_rdptr = count_m1[ADDR_W-1:0];
        end
        else
        begin
            dec_left  = count_m1 - CNT_W'(dec_at);
            dec_rdptr = dec_at + ADDR_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && dec_get)
                    state_next = ST_GET;
                else if (accept && dec_shift)
                    state_next = ST_SHIFT;
            end
            ST_GET:
            begin
                state_next = ST_IDLE;
            end
            ST_SHIFT:
            begin
                if (left_reg == '0 && !pend_reg)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath, RAM control and results
    // ------------------------------------------------------------------
    always_comb
    begin
        count_next     = count_reg;
        rd_ptr_next    = rd_ptr_reg;
        left_next      = left_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        ins_next       = ins_reg;
        at_next        = at_reg;
        val_next       = val_reg;
        done_next      = 1'b0;
        rv_next        = rv_reg;
        status_next    = status_reg;
        cnt_out_next   = cnt_out_reg;
        ram_we         = 1'b0;
        ram_waddr      = pend_addr_reg;
        ram_wdata      = ram_rdata;
        ram_re         = 1'b0;
        ram_raddr      = rd_ptr_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                ram_raddr = position[ADDR_W-1:0];
                if (accept)
                begin
                    ins_next    = dec_ins;
                    at_next     = dec_at;
                    val_next    = item_value;
                    left_next   = dec_left;
                    rd_ptr_next = dec_rdptr;
                    ram_re      = dec_get;
                    if (!dec_get && !dec_shift)
                    begin
                        // answered right away
                        done_next    = 1'b1;
                        rv_next      = dec_rv;
                        status_next  = dec_status;
                        cnt_out_next = count_reg;
                    end
                end
            end
            ST_GET:
            begin
                done_next    = 1'b1;
                rv_next      = ram_rdata;
                status_next  = STAT_DONE;
                cnt_out_next = count_reg;
            end
            ST_SHIFT:
            begin
                // read side runs one entry ahead of the write side
                if (left_reg != '0)
                begin
                    ram_re         = 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = rd_ptr_reg;
                    left_next      = left_reg - CNT_W'(1);
                    rd_ptr_next    = ins_reg ? rd_ptr_reg - ADDR_W'(1)
                                             : rd_ptr_reg + ADDR_W'(1);
                end
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = ins_reg ? pend_addr_reg + ADDR_W'(1)
                                        : pend_addr_reg - ADDR_W'(1);
                end
                else if (left_reg == '0)
                begin
                    // last cycle: drop in the new value, update count
                    ram_we       = ins_reg;
                    ram_waddr    = at_reg;
                    ram_wdata    = val_reg;
                    count_next   = ins_reg ? count_reg + CNT_W'(1) : count_m1;
                    done_next    = 1'b1;
                    rv_next      = '0;
                    status_next  = STAT_DONE;
                    cnt_out_next = count_next;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            left_reg  <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            left_reg  <= left_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg    <= rd_ptr_next;
        pend_addr_reg <= pend_addr_next;
        ins_reg       <= ins_next;
        at_reg        <= at_next;
        val_reg       <= val_next;
        rv_reg        <= rv_next;
        status_reg    <= status_next;
        cnt_out_reg   <= cnt_out_next;
    end

    ils_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign done       = done_reg;
    assign read_value = $signed(rv_reg);
    assign status     = status_reg;
    assign count      = cnt_out_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("list count above capacity");

    a_finish_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("command finished without a result");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("transfer neither answered nor in progress");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == $past(count_reg)
        || count_reg == $past(count_reg) + CNT_W'(1)
        || count_reg == $past(count_reg) - CNT_W'(1))
        else $error("count moved by more than one");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !ram_we)
        else $error("RAM write while idle");
`endif

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list store testbench
// Drives get/insert/delete commands into indexed_list_store_core through the
// start/busy handshake, predicts every result with a queue-based shadow of
// the list, and checks each done strobe against the oldest expectation.
// ----------------------------------------------------------------------------
module testbench;

    import ils_pkg::*;

    // Command codes the package leaves unnamed; the block treats them as no-ops.
    localparam logic [2:0]  CMD_RSVD_LO = 3'd5;
    localparam logic [2:0]  CMD_RSVD_HI = 3'd7;
    // read_value returned by a get at an invalid position.
    localparam logic [31:0] RD_INVALID  = 32'hFFFF_FFFF;
    // Cycles with no transfer and no result before the run is declared hung.
    // The limit covers the slowest command, a shift of a full list, plus a
    // sender gap at the heavy idle setting.
    localparam int          QUIET_LIMIT = 6000;
    // Settle time after the last result: rejects answer in the cycle after the
    // transfer, so a stray strobe would show well inside this window.
    localparam int          DRAIN_CYCLES = 16;
    localparam int          REPORT_MAX   = 10;

    typedef struct packed {
        logic [31:0] rd;
        logic [1:0]  st;
        logic [10:0] cnt;
    } list_result_t;

    // One row of the directed script. When 'fixed' is set, the result is
    // typed in the row; otherwise it comes from the shadow list.
    typedef struct packed {
        logic [2:0]   op;
        logic [11:0]  pos;
        logic [31:0]  val;
        logic         fixed;
        list_result_t res;
    } script_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic [2:0]                 cmd;
    logic signed [POS_W-1:0]    position;
    logic signed [DATA_W-1:0]   item_value;
    logic                       done;
    logic signed [DATA_W-1:0]   read_value;
    logic [STAT_W-1:0]          status;
    logic [CNT_W-1:0]           count;

    // Shadow of the list contents, head at index 0.
    logic [31:0]    shadow_list[$];
    list_result_t   expected_results[$];

    int sender_idle_pct;
    int error_total;
    int checked_total;
    int quiet_cycles;
    int peak_size;
    int range_seen;
    int full_seen;
    int op_count[8];

    // Directed opening, walked from reset. Rows with a typed result cover the
    // empty list, the field extremes and every out-of-range rejection; the rest
    // rely on the shadow list.
    script_row_t directed_script [25] = '{
        // empty list: every access is out of range, reserved code is a no-op
        '{CMD_GET,      12'h000, 32'h0000_0000, 1'b1, '{RD_INVALID, STAT_RANGE, 11'd0}},
        '{CMD_DELETE,   12'h000, 32'h0000_0000, 1'b1, '{32'h0, STAT_RANGE, 11'd0}},
        '{CMD_INS_AT,   12'h001, 32'h1111_1111, 1'b1, '{32'h0, STAT_RANGE, 11'd0}},
        '{CMD_RSVD_LO,  12'h000, 32'hFFFF_FFFF, 1'b1, '{32'h0, STAT_DONE,  11'd0}},
        // value extremes at both ends
        '{CMD_INS_TAIL, 12'h000, 32'h7FFF_FFFF, 1'b1, '{32'h0, STAT_DONE,  11'd1}},
        '{CMD_INS_HEAD, 12'h7FF, 32'h8000_0000, 1'b1, '{32'h0, STAT_DONE,  11'd2}},
        '{CMD_GET,      12'h000, 32'h0000_0000, 1'b1, '{32'h8000_0000, STAT_DONE, 11'd2}},
        '{CMD_GET,      12'h001, 32'h0000_0000, 1'b1, '{32'h7FFF_FFFF, STAT_DONE, 11'd2}},
        // get at count, at -1 and at both position extremes
        '{CMD_GET,      12'h002, 32'h0000_0000, 1'b1, '{RD_INVALID, STAT_RANGE, 11'd2}},
        '{CMD_GET,      12'hFFF, 32'h0000_0000, 1'b1, '{RD_INVALID, STAT_RANGE, 11'd2}},
        '{CMD_GET,      12'h7FF, 32'h0000_0000, 1'b1, '{RD_INVALID, STAT_RANGE, 11'd2}},
        '{CMD_GET,      12'h800, 32'h0000_0000, 1'b1, '{RD_INVALID, STAT_RANGE, 11'd2}},
        // insert at most negative index lands at the head, at count at the tail
        '{CMD_INS_AT,   12'h800, 32'h0000_0000, 1'b1, '{32'h0, STAT_DONE,  11'd3}},
        '{CMD_INS_AT,   12'h003, 32'hFFFF_FFFF, 1'b1, '{32'h0, STAT_DONE,  11'd4}},
        '{CMD_INS_AT,   12'h001, 32'h1234_5678, 1'b1, '{32'h0, STAT_DONE,  11'd5}},
        '{CMD_INS_AT,   12'h000, 32'hA5A5_A5A5, 1'b1, '{32'h0, STAT_DONE,  11'd6}},
        '{CMD_GET,      12'h001, 32'h0000_0000, 1'b0, '0},
        '{CMD_GET,      12'h005, 32'h0000_0000, 1'b0, '0},
        // insert far past count, delete at count and below zero
        '{CMD_INS_AT,   12'h7FF, 32'h5555_5555, 1'b1, '{32'h0, STAT_RANGE, 11'd6}},
        '{CMD_DELETE,   12'h006, 32'h0000_0000, 1'b1, '{32'h0, STAT_RANGE, 11'd6}},
        '{CMD_DELETE,   12'hFFF, 32'h0000_0000, 1'b1, '{32'h0, STAT_RANGE, 11'd6}},
        // delete last, first, middle
        '{CMD_DELETE,   12'h005, 32'h0000_0000, 1'b1, '{32'h0, STAT_DONE,  11'd5}},
        '{CMD_DELETE,   12'h000, 32'h0000_0000, 1'b1, '{32'h0, STAT_DONE,  11'd4}},
        '{CMD_DELETE,   12'h001, 32'h0000_0000, 1'b0, '0},
        '{CMD_RSVD_HI,  12'h123, 32'hDEAD_BEEF, 1'b1, '{32'h0, STAT_DONE,  11'd3}}
    };

    indexed_list_store_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .position   (position),
        .item_value (item_value),
        .done       (done),
        .read_value (read_value),
        .status     (status),
        .count      (count)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor: applies one accepted command to the shadow list and returns
    // the result the block must give for it.
    // ------------------------------------------------------------------------
    function automatic logic [1:0] shadow_put(input int at, input logic [31:0] val);
        // Full check only; callers have already ruled out a position past count.
        if (shadow_list.size() >= CAPACITY)
            return STAT_FULL;
        shadow_list.insert(at, val);
        return STAT_DONE;
    endfunction

    function automatic list_result_t list_apply(input logic [2:0] op,
                                                input logic [11:0] pos,
                                                input logic [31:0] val);
        list_result_t r;
        int p;
        int n;
        p    = $signed(pos);
        n    = shadow_list.size();
        r.rd = '0;
        r.st = STAT_DONE;
        case (op)
            CMD_GET:
                if (p < 0 || p >= n) begin
                    r.rd = RD_INVALID;
                    r.st = STAT_RANGE;
                end
                else
                    r.rd = shadow_list[p];
            CMD_INS_HEAD: r.st = shadow_put(0, val);
            CMD_INS_TAIL: r.st = shadow_put(n, val);
            CMD_INS_AT:
                // Range check comes ahead of the full check.
                if (p <= 0)
                    r.st = shadow_put(0, val);
                else if (p > n)
                    r.st = STAT_RANGE;
                else
                    r.st = shadow_put(p, val);
            CMD_DELETE:
                if (p < 0 || p >= n)
                    r.st = STAT_RANGE;
                else
                    shadow_list.delete(p);
            default: ;  // reserved codes leave the list alone
        endcase
        r.cnt = 11'(shadow_list.size());
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Sender. Fields change on the falling edge; the transfer happens at the
    // first rising edge with busy low. start stays high straight into the
    // next command when no gap is drawn, so it never gets two updates in one
    // time step.
    // ------------------------------------------------------------------------
    task automatic send_cmd(input logic [2:0] op, input logic [11:0] pos,
                            input logic [31:0] val, input logic fixed,
                            input list_result_t fixed_res);
        list_result_t predicted;
        @(negedge clk);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start      <= 1'b1;
        cmd        <= op;
        position   <= pos;
        item_value <= val;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        // transfer taken at this edge
        predicted = list_apply(op, pos, val);
        expected_results.push_back(fixed ? fixed_res : predicted);
        op_count[op]++;
        if (predicted.st == STAT_RANGE)
            range_seen++;
        if (predicted.st == STAT_FULL)
            full_seen++;
        if (shadow_list.size() > peak_size)
            peak_size = shadow_list.size();
    endtask

    function automatic logic [31:0] pick_value();
        // Corner values now and then, otherwise any 32-bit pattern.
        case ($urandom_range(0, 31))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Mixed traffic on a short list: positions mostly near the live range so
    // commands land, with the occasional wild 12-bit position and reserved
    // code. Once the list holds 40 entries, most inserts turn into deletes,
    // which keeps the shift loop short.
    task automatic run_mixed(input int n_items);
        int          k;
        int          sel;
        int          n;
        logic [2:0]  op;
        logic [11:0] pos;
        for (k = 0; k < n_items; k++) begin
            n   = shadow_list.size();
            sel = $urandom_range(0, 99);
            if (sel < 25)
                op = CMD_GET;
            else if (sel < 37)
                op = CMD_INS_HEAD;
            else if (sel < 49)
                op = CMD_INS_TAIL;
            else if (sel < 64)
                op = CMD_INS_AT;
            else if (sel < 94)
                op = CMD_DELETE;
            else
                op = 3'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
            if (n >= 40 && (op == CMD_INS_HEAD || op == CMD_INS_TAIL || op == CMD_INS_AT)
                    && $urandom_range(0, 9) < 6)
                op = CMD_DELETE;
            case ($urandom_range(0, 9))
                0:       pos = 12'($urandom);
                1:       pos = 12'(-$urandom_range(1, 3));
                default: pos = 12'($urandom_range(0, n + 1));
            endcase
            send_cmd(op, pos, pick_value(), 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checker: every done strobe is one transfer out, matched against
    // the oldest outstanding expectation.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : result_check
        list_result_t want;
        if (rst_n === 1'b1 && done === 1'b1) begin
            if (expected_results.size() == 0) begin
                error_total++;
                if (error_total <= REPORT_MAX)
                    $display("%0t: result with nothing outstanding: %s %h status %0d count %0d",
                             $realtime, "read_value", read_value, status, count);
            end
            else begin
                want = expected_results.pop_front();
                checked_total++;
                if (read_value !== want.rd || status !== want.st || count !== want.cnt) begin
                    error_total++;
                    if (error_total <= REPORT_MAX)
                        $display("%0t: result %0d mismatch: read_value exp %h got %h, %s",
                                 $realtime, checked_total, want.rd, read_value,
                                 $sformatf("status exp %0d got %0d, count exp %0d got %0d",
                                           want.st, status, want.cnt, count));
                end
            end
        end
    end

    // Watchdog: cycles with neither an input transfer nor a result.
    always @(posedge clk) begin
        if (rst_n === 1'b1) begin
            if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $realtime, QUIET_LIMIT, expected_results.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int r;
        rst_n           = 1'b0;
        start           = 1'b0;
        cmd             = CMD_GET;
        position        = '0;
        item_value      = '0;
        sender_idle_pct = 24;
        error_total     = 0;
        checked_total   = 0;
        quiet_cycles    = 0;
        peak_size       = 0;
        range_seen      = 0;
        full_seen       = 0;
        foreach (op_count[i])
            op_count[i] = 0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (r = 0; r < 25; r++)
            send_cmd(directed_script[r].op, directed_script[r].pos, directed_script[r].val,
                     directed_script[r].fixed, directed_script[r].res);

        // Sender gaps: moderate, then heavy, then back-to-back.
        sender_idle_pct = 24;
        run_mixed(185);
        sender_idle_pct = 66;
        run_mixed(185);
        sender_idle_pct = 0;
        run_mixed(185);

        @(negedge clk);
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        error_total += expected_results.size();

        $display("Covered %0d gets, %0d head / %0d tail / %0d indexed inserts, %0d deletes,",
                 op_count[CMD_GET], op_count[CMD_INS_HEAD], op_count[CMD_INS_TAIL],
                 op_count[CMD_INS_AT], op_count[CMD_DELETE]);
        $display("%0d reserved; %0d results checked; list peaked at %0d entries; %s",
                 op_count[5] + op_count[6] + op_count[7], checked_total, peak_size,
                 $sformatf("%0d out-of-range and %0d full-list rejections",
                           range_seen, full_seen));
        if (error_total == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
